/* rtl/core/aabb_pkg.sv */
// Shared widths and types for the axis-aligned box affine transform core.
package aabb_pkg;

    // Local box coordinates: signed integers.
    localparam int COORD_BITS = 16;
    // Matrix coefficients: signed fixed point with FRAC_BITS fraction bits.
    localparam int COEF_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    // Translation field: signed integer, scaled by 2^FRAC_BITS before the add.
    localparam int TRANS_BITS = 16;
    // Result width in units of 2^-FRAC_BITS.
    localparam int OUT_BITS   = 33;

    // Packed matrix row: three coefficients and the translation.
    localparam int ROW_BITS   = 3 * COEF_BITS + TRANS_BITS;
    localparam int NUM_AXES   = 3;

    // One coefficient times one coordinate.
    localparam int PROD_W     = COEF_BITS + COORD_BITS;
    // Three products plus the scaled translation, with headroom for the carries.
    localparam int SUM_W      = PROD_W + 2;
    // Sign bits needed to widen the scaled translation to SUM_W.
    localparam int TR_EXT_W   = SUM_W - TRANS_BITS - FRAC_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic signed [TRANS_BITS-1:0] trans_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [OUT_BITS-1:0]   result_t;
    typedef logic [ROW_BITS-1:0]          row_t;

endpackage

/* rtl/core/aabb_affine_transform_core.sv */
// Top level of the axis-aligned box affine transform core: a three-stage pipeline.
//
// The core takes one local box and one 3x4 fixed-point matrix per request and
// returns the box around all eight transformed corners, exact in units of
// 2^-14. Because each output axis is a sum of independent terms, the extreme
// over the eight corners equals the sum of the per-term extremes, so every
// coefficient is multiplied by both the box minimum and maximum of its
// coordinate. Stage one holds the eighteen 16x16 products, stage two the
// smaller and larger product of each pair, stage three the summed minimum and
// maximum per axis together with the translation. A void box yields all zeros.
// A request passes in order through the stage-one, stage-two and stage-three
// registers, and its result is valid while stage three holds it. One request is
// accepted every cycle while results are taken, since every stage is fully
// parallel. Each stage holds its item while the stage after it is full and
// stalled, so a stall drops and repeats nothing.
module aabb_affine_transform_core
    import aabb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,

    input  logic    in_valid,
    output logic    in_ready,
    input  logic    box_void,
    input  coord_t  box_min_x,
    input  coord_t  box_min_y,
    input  coord_t  box_min_z,
    input  coord_t  box_max_x,
    input  coord_t  box_max_y,
    input  coord_t  box_max_z,
    input  row_t    row_x,
    input  row_t    row_y,
    input  row_t    row_z,

    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_min_x,
    output result_t out_min_y,
    output result_t out_min_z,
    output result_t out_max_x,
    output result_t out_max_y,
    output result_t out_max_z
);

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic en1, en2, en3;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;

    // Unpacked views of the request.
    coord_t lo_in [NUM_AXES];
    coord_t hi_in [NUM_AXES];
    coef_t  coef_in [NUM_AXES][NUM_AXES];
    trans_t tr_in [NUM_AXES];
    row_t   rows_in [NUM_AXES];

    // Stage one: products with the minimum and maximum coordinates.
    prod_t  plo1_reg [NUM_AXES][NUM_AXES];
    prod_t  phi1_reg [NUM_AXES][NUM_AXES];
    prod_t  plo1_next [NUM_AXES][NUM_AXES];
    prod_t  phi1_next [NUM_AXES][NUM_AXES];
    trans_t tr1_reg [NUM_AXES];
    logic   void1_reg;

    // Stage two: per-term extremes.
    prod_t  mn2_reg [NUM_AXES][NUM_AXES];
    prod_t  mx2_reg [NUM_AXES][NUM_AXES];
    prod_t  mn2_next [NUM_AXES][NUM_AXES];
    prod_t  mx2_next [NUM_AXES][NUM_AXES];
    trans_t tr2_reg [NUM_AXES];
    logic   void2_reg;

    // Stage three: summed results.
    result_t rmin3_reg [NUM_AXES];
    result_t rmax3_reg [NUM_AXES];
    result_t rmin3_next [NUM_AXES];
    result_t rmax3_next [NUM_AXES];

    // Handshake and enable chain.
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign v1_next = en1 ? in_valid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Unpack coordinates and matrix rows.
    always_comb
    begin
        lo_in[0]   = box_min_x;
        lo_in[1]   = box_min_y;
        lo_in[2]   = box_min_z;
        hi_in[0]   = box_max_x;
        hi_in[1]   = box_max_y;
        hi_in[2]   = box_max_z;
        rows_in[0] = row_x;
        rows_in[1] = row_y;
        rows_in[2] = row_z;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                coef_in[a][j] = rows_in[a][j*COEF_BITS +: COEF_BITS];
            end
            tr_in[a] = rows_in[a][NUM_AXES*COEF_BITS +: TRANS_BITS];
        end
    end

    // Stage one: eighteen signed multiplications.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                plo1_next[a][j] = prod_t'(coef_in[a][j]) * prod_t'(lo_in[j]);
                phi1_next[a][j] = prod_t'(coef_in[a][j]) * prod_t'(hi_in[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            plo1_reg  <= plo1_next;
            phi1_reg  <= phi1_next;
            tr1_reg   <= tr_in;
            void1_reg <= box_void;
        end
    end

    // Stage two: pick the smaller and larger product of each pair.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (plo1_reg[a][j] < phi1_reg[a][j])
                begin
                    mn2_next[a][j] = plo1_reg[a][j];
                    mx2_next[a][j] = phi1_reg[a][j];
                end
                else
                begin
                    mn2_next[a][j] = phi1_reg[a][j];
                    mx2_next[a][j] = plo1_reg[a][j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            mn2_reg   <= mn2_next;
            mx2_reg   <= mx2_next;
            tr2_reg   <= tr1_reg;
            void2_reg <= void1_reg;
        end
    end

    // Stage three: add the extremes and the scaled translation per axis.
    always_comb
    begin
        sum_t tr_s;
        sum_t smin;
        sum_t smax;
        tr_s = '0;
        smin = '0;
        smax = '0;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            tr_s = {{TR_EXT_W{tr2_reg[a][TRANS_BITS-1]}}, tr2_reg[a], {FRAC_BITS{1'b0}}};
            smin = SUM_W'(mn2_reg[a][0]) + SUM_W'(mn2_reg[a][1])
                 + SUM_W'(mn2_reg[a][2]) + tr_s;
            smax = SUM_W'(mx2_reg[a][0]) + SUM_W'(mx2_reg[a][1])
                 + SUM_W'(mx2_reg[a][2]) + tr_s;
            rmin3_next[a] = void2_reg ? '0 : smin[OUT_BITS-1:0];
            rmax3_next[a] = void2_reg ? '0 : smax[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            rmin3_reg <= rmin3_next;
            rmax3_reg <= rmax3_next;
        end
    end

    // Output ports.
    assign out_valid = v3_reg;
    assign out_min_x = rmin3_reg[0];
    assign out_min_y = rmin3_reg[1];
    assign out_min_z = rmin3_reg[2];
    assign out_max_x = rmax3_reg[0];
    assign out_max_y = rmax3_reg[1];
    assign out_max_z = rmax3_reg[2];

    // A full pipeline under a stalled output takes no new request.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !out_ready) |-> !in_ready)
        else $error("request accepted into a full, stalled pipeline");

    // An item in stage one moves to stage two whenever stage two loads.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && en2) |=> v2_reg)
        else $error("item lost between stage one and stage two");

    // A void box leaves the pipeline as all zeros.
    a_void_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && en3 && void2_reg) |=>
            (out_min_x == '0 && out_max_x == '0 && out_min_y == '0 &&
             out_max_y == '0 && out_min_z == '0 && out_max_z == '0))
        else $error("void box produced a nonzero result");

    // The transformed box is never inverted.
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_min_x <= out_max_x && out_min_y <= out_max_y &&
                       out_min_z <= out_max_z))
        else $error("result minimum exceeds maximum");

endmodule
